/* rtl/bsc_pkg.sv */
package bsc_pkg;

  // Field widths
  localparam int RawW   = 24;
  localparam int CoefW  = 16;
  localparam int TempW  = 19;
  localparam int PresW  = 32;
  localparam int CfgIdxW = 3;

  // Internal widths
  localparam int DtW    = 25;  // D2 - C5*256
  localparam int ProdW  = 42;  // dT * coefficient
  localparam int DtSqW  = 49;  // dT * dT, never negative
  localparam int T2W    = 17;  // dT^2 >> 31
  localparam int TmpW   = 20;  // first-order temperature
  localparam int OffW   = 36;
  localparam int SensW  = 35;
  localparam int SqW    = 36;  // squared temperature deltas
  localparam int NetW   = 40;  // OFF - OFF2, SENS - SENS2
  localparam int HalfW  = 20;  // SENS split for the D1 product
  localparam int PlW    = RawW + HalfW;
  localparam int PhW    = RawW + HalfW + 1;
  localparam int AccW   = 53;  // low bits of D1*SENS needed for 32-bit P

  localparam int NStages = 8;

  localparam logic signed [TmpW-1:0] TempBase     = 20'sd2000;
  localparam logic signed [TmpW-1:0] TempVeryCold = -20'sd1500;

  typedef enum logic [CfgIdxW-1:0] {
    RegSensC1  = 3'd0,
    RegOffC2   = 3'd1,
    RegTcsC3   = 3'd2,
    RegTcoC4   = 3'd3,
    RegTrefC5  = 3'd4,
    RegTempC6  = 3'd5
  } cfg_reg_e;

endpackage

/* rtl/baro_sensor_compensation.sv */
// Channel   Dir  Data                                   Side band
// s_axis    in   tdata[23:0] raw_pressure (D1)          -
//                tdata[47:24] raw_temperature (D2)
// m_axis    out  tdata[18:0] temp_centi                 tuser[0] cold_correction
//                tdata[50:19] pressure_pa, rest zero    tuser[1] very_cold_correction
// cfg       in   cfg_index_i register, cfg_data_i value  cfg_ready_o always high
//
// Eight register stages; a conversion pair enters every cycle while the output
// side does not stall, and its result leaves from the stage 8 output register.
// Depth is set by the D1 * SENS product, cut into two partial products and a
// separate combine stage, plus the squaring stage for the cold corrections.
// Reset clears the stage valids and the calibration registers to zero.
// A stall holds only the stages that are full; bubbles ahead still close up,
// so s_axis_tready stays high while the pipe has a free slot.
module baro_sensor_compensation (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input conversions
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // raw_pressure, raw_temperature
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // temp_centi, pressure_pa, zero pad
  output logic [1:0]  m_axis_tuser,   // cold_correction, very_cold_correction
  // calibration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int N = bsc_pkg::NStages;

  // ---------------------------------------------------------------------------
  // Calibration registers
  // ---------------------------------------------------------------------------
  logic [bsc_pkg::CoefW-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
      c5_q <= '0;
      c6_q <= '0;
    end else if (cfg_valid_i) begin
      case (bsc_pkg::cfg_reg_e'(cfg_index_i))
        bsc_pkg::RegSensC1: c1_q <= cfg_data_i;
        bsc_pkg::RegOffC2:  c2_q <= cfg_data_i;
        bsc_pkg::RegTcsC3:  c3_q <= cfg_data_i;
        bsc_pkg::RegTcoC4:  c4_q <= cfg_data_i;
        bsc_pkg::RegTrefC5: c5_q <= cfg_data_i;
        bsc_pkg::RegTempC6: c6_q <= cfg_data_i;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage control: a stage moves when it is empty or the one after it moves
  // ---------------------------------------------------------------------------
  logic [N-1:0] vld_q, vld_d, en;

  always_comb begin
    en[N-1] = !vld_q[N-1] || m_axis_tready;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d[0] = en[0] ? s_axis_tvalid : vld_q[0];
    for (int k = 1; k < N; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = en[0];

  // ---------------------------------------------------------------------------
  // Stage 1: dT = D2 - C5*256
  // ---------------------------------------------------------------------------
  logic [bsc_pkg::RawW-1:0]       d1_s1_q;
  logic signed [bsc_pkg::DtW-1:0] dt_s1_q, dt_s1_d;

  assign dt_s1_d = $signed({1'b0, s_axis_tdata[47:24]}) - $signed({1'b0, c5_q, 8'h00});

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      d1_s1_q <= s_axis_tdata[23:0];
      dt_s1_q <= dt_s1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the four products of dT
  // ---------------------------------------------------------------------------
  logic [bsc_pkg::RawW-1:0]          d1_s2_q;
  logic signed [bsc_pkg::ProdW-1:0]  p6_s2_q, p4_s2_q, p3_s2_q;
  logic signed [bsc_pkg::ProdW-1:0]  p6_s2_d, p4_s2_d, p3_s2_d;
  logic signed [bsc_pkg::DtSqW-1:0]  pdd_s2_q, pdd_s2_d;

  always_comb begin
    p6_s2_d  = dt_s1_q * $signed({1'b0, c6_q});
    p4_s2_d  = dt_s1_q * $signed({1'b0, c4_q});
    p3_s2_d  = dt_s1_q * $signed({1'b0, c3_q});
    pdd_s2_d = dt_s1_q * dt_s1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      d1_s2_q  <= d1_s1_q;
      p6_s2_q  <= p6_s2_d;
      p4_s2_q  <= p4_s2_d;
      p3_s2_q  <= p3_s2_d;
      pdd_s2_q <= pdd_s2_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: first-order TEMP, OFF, SENS and T2 (upper slices = floor shifts)
  // ---------------------------------------------------------------------------
  logic [bsc_pkg::RawW-1:0]         d1_s3_q;
  logic signed [bsc_pkg::TmpW-1:0]  temp_s3_q, temp_s3_d;
  logic signed [bsc_pkg::OffW-1:0]  off_s3_q, off_s3_d;
  logic signed [bsc_pkg::SensW-1:0] sens_s3_q, sens_s3_d;
  logic [bsc_pkg::T2W-1:0]          t2_s3_q;

  always_comb begin
    temp_s3_d = $signed({p6_s2_q[41], p6_s2_q[41:23]}) + bsc_pkg::TempBase;
    off_s3_d  = $signed({4'b0, c2_q, 16'b0}) + $signed({p4_s2_q[41], p4_s2_q[41:7]});
    sens_s3_d = $signed({4'b0, c1_q, 15'b0}) + $signed({p3_s2_q[41], p3_s2_q[41:8]});
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      d1_s3_q   <= d1_s2_q;
      temp_s3_q <= temp_s3_d;
      off_s3_q  <= off_s3_d;
      sens_s3_q <= sens_s3_d;
      t2_s3_q   <= pdd_s2_q[47:31];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: cold flags, squared deltas, final temperature
  // ---------------------------------------------------------------------------
  logic [bsc_pkg::RawW-1:0]         d1_s4_q;
  logic signed [bsc_pkg::OffW-1:0]  off_s4_q;
  logic signed [bsc_pkg::SensW-1:0] sens_s4_q;
  logic signed [bsc_pkg::TmpW-1:0]  da_s4, db_s4, tfin_s4;
  logic signed [bsc_pkg::SqW-1:0]   sqa_s4_q, sqb_s4_q, sqa_s4_d, sqb_s4_d;
  logic [bsc_pkg::TempW-1:0]        temp_s4_q;
  logic                             cold_s4_d, vcold_s4_d, cold_s4_q, vcold_s4_q;

  always_comb begin
    da_s4      = temp_s3_q - bsc_pkg::TempBase;
    db_s4      = temp_s3_q - bsc_pkg::TempVeryCold;
    sqa_s4_d   = da_s4 * da_s4;
    sqb_s4_d   = db_s4 * db_s4;
    cold_s4_d  = temp_s3_q < bsc_pkg::TempBase;
    vcold_s4_d = temp_s3_q < bsc_pkg::TempVeryCold;
    // T2 only applies below 20.00 C
    tfin_s4    = cold_s4_d ? temp_s3_q - $signed({3'b0, t2_s3_q}) : temp_s3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      d1_s4_q    <= d1_s3_q;
      off_s4_q   <= off_s3_q;
      sens_s4_q  <= sens_s3_q;
      sqa_s4_q   <= sqa_s4_d;
      sqb_s4_q   <= sqb_s4_d;
      temp_s4_q  <= tfin_s4[bsc_pkg::TempW-1:0];
      cold_s4_q  <= cold_s4_d;
      vcold_s4_q <= vcold_s4_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: second-order terms and net OFF / SENS
  // All squared terms are non-negative, so plain shifts give the floor.
  // ---------------------------------------------------------------------------
  logic [bsc_pkg::RawW-1:0]        d1_s5_q;
  logic signed [bsc_pkg::NetW-1:0] sq5a, sq7b, sq11b, off2, sens2;
  logic signed [bsc_pkg::NetW-1:0] offn_s5_q, sensn_s5_q, offn_s5_d, sensn_s5_d;
  logic [bsc_pkg::TempW-1:0]       temp_s5_q;
  logic                            cold_s5_q, vcold_s5_q;

  always_comb begin
    sq5a  = (bsc_pkg::NetW'(sqa_s4_q) <<< 2) + bsc_pkg::NetW'(sqa_s4_q);
    sq7b  = (bsc_pkg::NetW'(sqb_s4_q) <<< 3) - bsc_pkg::NetW'(sqb_s4_q);
    sq11b = (bsc_pkg::NetW'(sqb_s4_q) <<< 3) + (bsc_pkg::NetW'(sqb_s4_q) <<< 1)
            + bsc_pkg::NetW'(sqb_s4_q);
    off2  = '0;
    sens2 = '0;
    if (cold_s4_q) begin
      off2  = sq5a >>> 1;
      sens2 = sq5a >>> 2;
      if (vcold_s4_q) begin
        off2  = off2 + sq7b;
        sens2 = sens2 + (sq11b >>> 1);
      end
    end
    offn_s5_d  = bsc_pkg::NetW'(off_s4_q) - off2;
    sensn_s5_d = bsc_pkg::NetW'(sens_s4_q) - sens2;
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      d1_s5_q    <= d1_s4_q;
      offn_s5_q  <= offn_s5_d;
      sensn_s5_q <= sensn_s5_d;
      temp_s5_q  <= temp_s4_q;
      cold_s5_q  <= cold_s4_q;
      vcold_s5_q <= vcold_s4_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: D1 * SENS as two partial products
  // ---------------------------------------------------------------------------
  logic [bsc_pkg::PlW-1:0]         pl_s6_q, pl_s6_d;
  logic signed [bsc_pkg::PhW-1:0]  ph_s6_q, ph_s6_d;
  logic signed [bsc_pkg::NetW-1:0] offn_s6_q;
  logic [bsc_pkg::TempW-1:0]       temp_s6_q;
  logic                            cold_s6_q, vcold_s6_q;

  always_comb begin
    pl_s6_d = d1_s5_q * sensn_s5_q[bsc_pkg::HalfW-1:0];
    ph_s6_d = $signed({1'b0, d1_s5_q}) * $signed(sensn_s5_q[bsc_pkg::NetW-1:bsc_pkg::HalfW]);
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      pl_s6_q    <= pl_s6_d;
      ph_s6_q    <= ph_s6_d;
      offn_s6_q  <= offn_s5_q;
      temp_s6_q  <= temp_s5_q;
      cold_s6_q  <= cold_s5_q;
      vcold_s6_q <= vcold_s5_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: combine partial products, modulo 2^53 (enough for 32-bit P)
  // ---------------------------------------------------------------------------
  logic [bsc_pkg::AccW-1:0]  acc_s7_q, acc_s7_d;
  logic [bsc_pkg::PresW-1:0] offsh_s7_q, offsh_s7_d;
  logic [bsc_pkg::TempW-1:0] temp_s7_q;
  logic                      cold_s7_q, vcold_s7_q;

  always_comb begin
    acc_s7_d   = {ph_s6_q[32:0], {bsc_pkg::HalfW{1'b0}}} + {9'b0, pl_s6_q};
    // OFF >> 15, sign-extended to 32 bits
    offsh_s7_d = {{7{offn_s6_q[39]}}, offn_s6_q[39:15]};
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      acc_s7_q   <= acc_s7_d;
      offsh_s7_q <= offsh_s7_d;
      temp_s7_q  <= temp_s6_q;
      cold_s7_q  <= cold_s6_q;
      vcold_s7_q <= vcold_s6_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8: P = (D1*SENS >> 21) - (OFF >> 15), output register
  // ---------------------------------------------------------------------------
  logic [bsc_pkg::PresW-1:0] pres_q;
  logic [bsc_pkg::TempW-1:0] temp_q;
  logic                      cold_q, vcold_q;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      pres_q  <= acc_s7_q[52:21] - offsh_s7_q;
      temp_q  <= temp_s7_q;
      cold_q  <= cold_s7_q;
      vcold_q <= vcold_s7_q;
    end
  end

  assign m_axis_tvalid = vld_q[N-1];
  assign m_axis_tdata  = {5'b0, pres_q, temp_q};
  assign m_axis_tuser  = {vcold_q, cold_q};

`ifndef ASSERT_OFF
  a_vcold_implies_cold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[0] || !m_axis_tuser[1]))
    else $error("very cold flag without cold flag");

  a_cold_temp_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> ($signed(m_axis_tdata[18:0]) < 19'sd2000))
    else $error("cold result at or above 20.00 C");

  a_warm_temp_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> ($signed(m_axis_tdata[18:0]) >= 19'sd2000))
    else $error("warm result below 20.00 C");

  a_empty_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input held off while output stage empty");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&vld_q && !m_axis_tready) |=> (&vld_q && $stable(pres_q)))
    else $error("full pipe lost an item under stall");
`endif

endmodule
